// ===== rtl/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int WIN_SIDE   = 3;
  localparam int WIN_SIZE   = WIN_SIDE * WIN_SIDE;
  localparam int CFG_IDX_W  = 1;
  localparam int MIN_SIZE   = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // 3x3 window, entry row*3+col, row 0 oldest line, col 2 newest pixel
  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

  // Position tag carried alongside a window through the sorter
  typedef struct packed {
    logic [COL_W-1:0] centre_col;
    logic [ROW_W-1:0] centre_row;
    logic             frame_last;
  } pos_t;

  // Line store word: two rows above ({b, a})
  typedef struct packed {
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
  } line_word_t;

endpackage

`default_nettype wire

// ===== rtl/median_filter_3x3_top.sv =====
// Top level of the 3x3 median filter: position counters, line store
// read-modify-write, window shift and size registers. Uses mf3_pkg,
// mf3_line_mem and mf3_median.
// Path to out_*: stage 1, then sorter input, sort, extreme and output registers.
// Throughput: one pixel per cycle unless out_ready stalls; the line store is read
// on accept and written back as it leaves stage 1, so each column costs one slot.
// Reset: counters, valid bits and the window clear; sizes return to 1024x1024.
// Line store contents are undefined after reset; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_top
  import mf3_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_median_value,
  output logic [COL_W-1:0]          out_centre_col,
  output logic [ROW_W-1:0]          out_centre_row,
  output logic                      out_frame_last,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    if (v < SIZE_W'(MIN_SIZE)) return SIZE_W'(MIN_SIZE);
    else if (v > hi)           return hi;
    else                       return v;
  endfunction

  logic [SIZE_W-1:0] fw_r, fh_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic              s1_v_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;

  win_t              win_r, win_nxt;
  line_word_t        mem_rdata, mem_wdata;
  logic              accept, s1_emit, s1_leave, med_ready;
  pos_t              s1_tag, out_tag;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= SIZE_W'(MAX_WIDTH);
      fh_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  fw_r <= clamp_size(cfg_data, SIZE_W'(MAX_WIDTH));
        CFG_FRAME_HEIGHT: fh_r <= clamp_size(cfg_data, SIZE_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // Input handshake: stage 1 frees when its transaction leaves
  assign s1_leave = s1_v_r && (!s1_emit || med_ready);
  assign in_ready = !s1_v_r || s1_leave;
  assign accept   = in_valid && in_ready;

  // Raster position counters, wrapping at the configured size
  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if ((SIZE_W'(col_r) + SIZE_W'(1)) >= fw_r) begin
      col_nxt = '0;
      if ((SIZE_W'(row_r) + SIZE_W'(1)) >= fh_r) row_nxt = '0;
      else                                       row_nxt = row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_ready) s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // Line store: read on accept, write back as the transaction leaves stage 1.
  // Consecutive transactions hit distinct columns (width >= 3), so no forwarding.
  assign mem_wdata.above2 = mem_rdata.above1;
  assign mem_wdata.above1 = s1_px_r;

  mf3_line_mem u_line_mem (
    .clk   (clk),
    .re    (accept),
    .raddr (col_r),
    .rdata (mem_rdata),
    .we    (s1_leave),
    .waddr (s1_col_r),
    .wdata (mem_wdata)
  );

  // Window shift: columns move left, newest column enters on the right
  always_comb begin
    for (int k = 0; k < WIN_SIDE; k++) begin
      win_nxt[k*WIN_SIDE + 0] = win_r[k*WIN_SIDE + 1];
      win_nxt[k*WIN_SIDE + 1] = win_r[k*WIN_SIDE + 2];
    end
    win_nxt[0*WIN_SIDE + 2] = mem_rdata.above2;
    win_nxt[1*WIN_SIDE + 2] = mem_rdata.above1;
    win_nxt[2*WIN_SIDE + 2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_leave) begin
      win_r <= win_nxt;
    end
  end

  // Interior centre test and frame-end marker
  always_comb begin
    s1_emit = (SIZE_W'(s1_col_r) < fw_r) && (SIZE_W'(s1_row_r) < fh_r) &&
              (s1_col_r >= COL_W'(2)) && (s1_row_r >= ROW_W'(2));
    s1_tag.centre_col = s1_col_r - COL_W'(1);
    s1_tag.centre_row = s1_row_r - ROW_W'(1);
    s1_tag.frame_last = ((SIZE_W'(s1_col_r) + SIZE_W'(1)) == fw_r) &&
                        ((SIZE_W'(s1_row_r) + SIZE_W'(1)) == fh_r);
  end

  mf3_median u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_v_r && s1_emit),
    .in_ready   (med_ready),
    .in_win     (win_nxt),
    .in_tag     (s1_tag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median_value),
    .out_tag    (out_tag)
  );

  assign out_centre_col = out_tag.centre_col;
  assign out_centre_row = out_tag.centre_row;
  assign out_frame_last = out_tag.frame_last;

  // Checks
  a_no_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_leave |-> col_r != s1_col_r)
    else $error("line store read and write hit the same column");

  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted transaction missing from stage 1");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |->
      (SIZE_W'(out_centre_col) == fw_r - SIZE_W'(2)) &&
      (SIZE_W'(out_centre_row) == fh_r - SIZE_W'(2)))
    else $error("frame end marked away from last interior pixel");

endmodule

`default_nettype wire

// ===== rtl/mf3_line_mem.sv =====
// Line store memory: both buffered rows packed in one word per column.
// One write port, one read port, read data registered. Uses mf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_mem
  import mf3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             re,
  input  wire logic [COL_W-1:0] raddr,
  output line_word_t            rdata,
  input  wire logic             we,
  input  wire logic [COL_W-1:0] waddr,
  input  wire line_word_t       wdata
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mf3_median.sv =====
// Pipelined median-of-nine sorter with valid/ready flow control per stage.
// Input register, column sort, row extremes, final median into the output register. Uses mf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf3_median
  import mf3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire win_t             in_win,
  input  wire pos_t             in_tag,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_median,
  output pos_t                  out_tag
);

  typedef struct packed {
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] lo;
  } trio_t;

  function automatic trio_t sort3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                  input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] x, y, z, t;
    trio_t res;
    x = a;
    y = b;
    z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    res.lo  = x;
    res.mid = y;
    res.hi  = z;
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // Stage registers
  logic                  a_v_r, b_v_r, c_v_r, o_v_r;
  win_t                  a_win_r;
  pos_t                  a_tag_r, b_tag_r, c_tag_r, o_tag_r;
  trio_t [WIN_SIDE-1:0]  b_col_r;
  trio_t                 c_trio_r;
  logic [PIX_W-1:0]      o_med_r;

  logic a_rdy, b_rdy, c_rdy, o_rdy;
  trio_t [WIN_SIDE-1:0]  col_nxt;
  trio_t                 trio_nxt;

  // Bubble-collapsing ready chain
  assign o_rdy    = !o_v_r || out_ready;
  assign c_rdy    = !c_v_r || o_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  // Sort each window column
  always_comb begin
    for (int j = 0; j < WIN_SIDE; j++) begin
      col_nxt[j] = sort3(a_win_r[j], a_win_r[WIN_SIDE + j], a_win_r[2*WIN_SIDE + j]);
    end
  end

  // Max of lows, median of mids, min of highs
  always_comb begin
    trio_nxt.lo  = max3(b_col_r[0].lo,  b_col_r[1].lo,  b_col_r[2].lo);
    trio_nxt.mid = med3(b_col_r[0].mid, b_col_r[1].mid, b_col_r[2].mid);
    trio_nxt.hi  = min3(b_col_r[0].hi,  b_col_r[1].hi,  b_col_r[2].hi);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
      if (o_rdy) o_v_r <= c_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_win_r <= in_win;
      a_tag_r <= in_tag;
    end
    if (b_rdy && a_v_r) begin
      b_col_r <= col_nxt;
      b_tag_r <= a_tag_r;
    end
    if (c_rdy && b_v_r) begin
      c_trio_r <= trio_nxt;
      c_tag_r  <= b_tag_r;
    end
    if (o_rdy && c_v_r) begin
      o_med_r <= med3(c_trio_r.lo, c_trio_r.mid, c_trio_r.hi);
      o_tag_r <= c_tag_r;
    end
  end

  assign out_valid  = o_v_r;
  assign out_median = o_med_r;
  assign out_tag    = o_tag_r;

  // Checks
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && b_v_r && c_v_r && o_v_r && !out_ready |-> !in_ready)
    else $error("sorter accepted while every stage was blocked");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !o_v_r |-> in_ready)
    else $error("sorter refused input with empty output stage");

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !c_rdy |=> b_v_r && $stable(b_col_r) && $stable(b_tag_r))
    else $error("stalled column-sort stage lost its contents");

endmodule

`default_nettype wire
